// ===== rtl/core/stsd_pkg.sv =====
// Shared types, field widths and codes for the sorted table unit.
package stsd_pkg;

	localparam int CAPACITY_DEF   = 16;
	localparam int VALUE_BITS_DEF = 32;

	localparam int KIND_W   = 2;
	localparam int VALUE_W  = 32;
	localparam int STATUS_W = 3;
	localparam int COUNT_W  = 5;
	localparam int OUT_W    = 8;

	typedef enum logic [KIND_W-1:0] {
		KIND_INSERT = 2'd0,
		KIND_SEARCH = 2'd1,
		KIND_DELETE = 2'd2
	} kind_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_INSERTED  = 3'd0,
		ST_FOUND     = 3'd1,
		ST_NOT_FOUND = 3'd2,
		ST_DELETED   = 3'd3,
		ST_EMPTY     = 3'd4,
		ST_FULL      = 3'd5
	} status_t;

	// controller to datapath
	typedef struct packed {
		logic capture;  // register operation and compare vectors
		logic commit;   // update table and count, load result register
	} stsd_cmd_t;

endpackage

// ===== rtl/core/stsd_ctrl.sv =====
// Controller: sequences capture and commit, owns the handshakes.
module stsd_ctrl
	import stsd_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	output logic      out_valid,
	input  logic      out_ready,
	output stsd_cmd_t cmd
);

	typedef enum logic [1:0] {
		S_IDLE  = 2'b01,
		S_APPLY = 2'b10
	} state_t;

	state_t state_q, state_d;
	logic   out_valid_q;
	logic   out_free;

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;
	assign out_free  = !out_valid_q || out_ready;

	always_comb begin
		state_d     = state_q;
		cmd.capture = 1'b0;
		cmd.commit  = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_d     = S_APPLY;
				end
			end
			S_APPLY: begin
				// wait until the result register can take the new result
				if (out_free) begin
					cmd.commit = 1'b1;
					state_d    = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.commit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

// ===== rtl/core/stsd_dp.sv =====
// Datapath: table cells, parallel compare, shift, count and result register.
module stsd_dp
	import stsd_pkg::*;
#(
	parameter int CAPACITY   = CAPACITY_DEF,
	parameter int VALUE_BITS = VALUE_BITS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  stsd_cmd_t           cmd,
	input  logic [KIND_W-1:0]   kind,
	input  logic [VALUE_W-1:0]  value,
	output logic [STATUS_W-1:0] status,
	output logic [COUNT_W-1:0]  entry_count
);

	localparam int CNT_W = $clog2(CAPACITY + 1);

	logic [VALUE_BITS-1:0] cell_q [CAPACITY];
	logic [CNT_W-1:0]      count_q;

	logic [VALUE_BITS-1:0] val_in;
	logic [CAPACITY-1:0]   lt_now, eq_now;

	kind_t                 kind_s1;
	logic [VALUE_BITS-1:0] val_s1;
	logic [CAPACITY-1:0]   lt_s1, eq_s1;

	logic                  full, empty, hit;
	logic                  do_ins, do_del;
	status_t               status_d;
	logic [CNT_W-1:0]      count_d;
	logic [CNT_W+COUNT_W-1:0] count_ext;

	status_t               status_q;
	logic [COUNT_W-1:0]    entry_count_q;

	// low VALUE_BITS of the operand; sign-extended when the table is wider than the bus
	assign val_in = VALUE_BITS'($signed(value));

	// compare against every valid cell at once; cells past the count read as no match
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cmp
		logic valid;
		assign valid     = (count_q > CNT_W'(i));
		assign lt_now[i] = valid && ($signed(cell_q[i]) < $signed(val_in));
		assign eq_now[i] = valid && (cell_q[i] == val_in);
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			kind_s1 <= kind_t'(kind);
			val_s1  <= val_in;
			lt_s1   <= lt_now;
			eq_s1   <= eq_now;
		end
	end

	assign full  = (count_q == CNT_W'(CAPACITY));
	assign empty = (count_q == '0);
	assign hit   = |eq_s1;

	always_comb begin
		do_ins   = 1'b0;
		do_del   = 1'b0;
		count_d  = count_q;
		status_d = ST_NOT_FOUND;
		case (kind_s1)
			KIND_INSERT: begin
				if (full) begin
					status_d = ST_FULL;
				end else begin
					do_ins   = 1'b1;
					count_d  = count_q + 1'b1;
					status_d = ST_INSERTED;
				end
			end
			KIND_DELETE: begin
				if (empty) begin
					status_d = ST_EMPTY;
				end else if (hit) begin
					do_del   = 1'b1;
					count_d  = count_q - 1'b1;
					status_d = ST_DELETED;
				end
			end
			default: status_d = hit ? ST_FOUND : ST_NOT_FOUND;
		endcase
	end

	// Table is sorted, so lt_s1 is a run of ones from cell 0: the first clear bit
	// is the insert slot and, on a hit, also the first equal entry.
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		always_ff @(posedge clk) begin
			if (cmd.commit && !lt_s1[i]) begin
				if (do_ins) begin
					if (i == 0) begin
						cell_q[i] <= val_s1;
					end else if (lt_s1[(i == 0) ? 0 : i - 1]) begin
						cell_q[i] <= val_s1;
					end else begin
						cell_q[i] <= cell_q[(i == 0) ? 0 : i - 1];
					end
				end else if (do_del && (i < CAPACITY - 1)) begin
					cell_q[i] <= cell_q[(i < CAPACITY - 1) ? i + 1 : i];
				end
			end
		end
	end

	assign count_ext = {{COUNT_W{1'b0}}, count_d};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cmd.commit) begin
			count_q <= count_d;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			status_q      <= status_d;
			entry_count_q <= count_ext[COUNT_W-1:0];
		end
	end

	assign status      = status_q;
	assign entry_count = entry_count_q;

endmodule

// ===== rtl/core/sorted_table_insert_search_delete_unit.sv =====
// Sorted table unit: keeps signed values in ascending order; insert, search, delete.
//
// Each input transaction is one operation and yields exactly one result transaction.
// An operation has a capture step and a commit step: in the accept cycle the operand is
// compared with all stored entries in parallel and the compare vectors are registered;
// in the commit step the table shifts in one step, the count updates and the result
// register loads. No new operation is taken until the current one has committed, and a
// waiting result holds the commit step until the result register frees up. Code 3 in kind
// acts as a search. Only the low VALUE_BITS bits of value are used, read as signed.
module sorted_table_insert_search_delete_unit
	import stsd_pkg::*;
#(
	parameter int CAPACITY   = CAPACITY_DEF,
	parameter int VALUE_BITS = VALUE_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_axis_tvalid,
	output logic               s_axis_tready,
	input  logic [VALUE_W-1:0] s_axis_tdata,   // [31:0] value
	input  logic [KIND_W-1:0]  s_axis_tuser,   // [1:0] kind
	output logic               m_axis_tvalid,
	input  logic               m_axis_tready,
	output logic [OUT_W-1:0]   m_axis_tdata    // [2:0] status, [7:3] entry_count
);

	stsd_cmd_t             cmd;
	logic [STATUS_W-1:0]   status;
	logic [COUNT_W-1:0]    entry_count;

	stsd_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.cmd       (cmd)
	);

	stsd_dp #(
		.CAPACITY   (CAPACITY),
		.VALUE_BITS (VALUE_BITS)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.kind        (s_axis_tuser),
		.value       (s_axis_tdata),
		.status      (status),
		.entry_count (entry_count)
	);

	assign m_axis_tdata = {entry_count, status};

endmodule

// ===== test/tb_sorted_table_insert_search_delete_unit.sv =====
// Testbench for the sorted table unit: directed and random insert/search/delete with checking.
`timescale 1ns / 1ps

module tb_sorted_table_insert_search_delete_unit;
	import stsd_pkg::*;

	localparam int CAPACITY = CAPACITY_DEF;
	localparam int CYCLE_LIMIT = 200000;
	localparam int DRAIN_CYCLES = 16;
	localparam logic [KIND_W-1:0] KIND_SPARE = 2'd3;  // unused code, behaves as search
	localparam logic signed [VALUE_W-1:0] VAL_MIN = 32'sh8000_0000;
	localparam logic signed [VALUE_W-1:0] VAL_MAX = 32'sh7fff_ffff;

	typedef struct packed {
		status_t            status;
		logic [COUNT_W-1:0] count;
	} op_result_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               s_axis_tvalid = 1'b0;
	logic               s_axis_tready;
	logic [VALUE_W-1:0] s_axis_tdata = '0;   // [31:0] value
	logic [KIND_W-1:0]  s_axis_tuser = '0;   // [1:0] kind
	logic               m_axis_tvalid;
	logic               m_axis_tready = 1'b0;
	logic [OUT_W-1:0]   m_axis_tdata;       // [2:0] status, [7:3] entry_count

	// shadow copy of the table, kept in ascending order
	logic signed [VALUE_W-1:0] shadow_vals [CAPACITY];
	int                        shadow_fill = 0;

	op_result_t pending_results [$];
	int         mismatch_count = 0;
	int         cycle_count = 0;
	bit         src_idle = 1'b0;
	bit         sink_idle = 1'b0;
	int         stall_left = 0;

	sorted_table_insert_search_delete_unit dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tuser (s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata)
	);

	always #4 clk = ~clk;

	function automatic op_result_t table_apply(input logic [KIND_W-1:0] kind,
			input logic signed [VALUE_W-1:0] v);
		op_result_t res;
		int pos;
		int i;
		bit hit;
		hit = 1'b0;
		pos = 0;
		if (kind == KIND_INSERT) begin
			if (shadow_fill >= CAPACITY) begin
				res.status = ST_FULL;
			end else begin
				// new value goes ahead of any equal copies
				while (pos < shadow_fill && shadow_vals[pos] < v)
					pos++;
				for (i = shadow_fill; i > pos; i--)
					shadow_vals[i] = shadow_vals[i-1];
				shadow_vals[pos] = v;
				shadow_fill++;
				res.status = ST_INSERTED;
			end
		end else if (kind == KIND_DELETE) begin
			if (shadow_fill == 0) begin
				res.status = ST_EMPTY;
			end else begin
				while (pos < shadow_fill && shadow_vals[pos] != v)
					pos++;
				if (pos >= shadow_fill) begin
					res.status = ST_NOT_FOUND;
				end else begin
					for (i = pos; i + 1 < shadow_fill; i++)
						shadow_vals[i] = shadow_vals[i+1];
					shadow_fill--;
					res.status = ST_DELETED;
				end
			end
		end else begin
			for (i = 0; i < shadow_fill && shadow_vals[i] <= v; i++)
				if (shadow_vals[i] == v)
					hit = 1'b1;
			res.status = hit ? ST_FOUND : ST_NOT_FOUND;
		end
		res.count = COUNT_W'(shadow_fill);
		return res;
	endfunction

	function automatic int draw_gap();
		int roll;
		if (!src_idle)
			return 0;
		roll = $urandom_range(0, 99);
		if (roll < 55)
			return 0;
		if (roll < 90)
			return $urandom_range(1, 3);
		return $urandom_range(4, 24);
	endfunction

	// values biased toward stored entries and edges so hits and duplicates happen
	function automatic logic signed [VALUE_W-1:0] pick_value();
		int roll;
		roll = $urandom_range(0, 9);
		if (roll < 4 && shadow_fill > 0)
			return shadow_vals[$urandom_range(0, shadow_fill - 1)];
		if (roll < 7)
			return $signed(VALUE_W'($urandom_range(0, 16))) - 8;
		if (roll == 7) begin
			case ($urandom_range(0, 3))
				0: return VAL_MIN;
				1: return VAL_MAX;
				2: return 0;
				default: return -1;
			endcase
		end
		return $urandom;
	endfunction

	task automatic send_op(input logic [KIND_W-1:0] kind, input logic signed [VALUE_W-1:0] v);
		int gap;
		gap = draw_gap();
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= v;
		s_axis_tuser <= kind;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		pending_results.push_back(table_apply(kind, v));
	endtask

	task automatic test_empty_table();
		send_op(KIND_SEARCH, 0);
		send_op(KIND_DELETE, -5);
		send_op(KIND_SPARE, 0);
	endtask

	task automatic test_extremes();
		send_op(KIND_INSERT, VAL_MIN);
		send_op(KIND_INSERT, VAL_MAX);
		send_op(KIND_INSERT, 0);
		send_op(KIND_INSERT, -1);
		send_op(KIND_INSERT, VAL_MAX);
		send_op(KIND_SEARCH, VAL_MIN);
		send_op(KIND_SEARCH, VAL_MAX);
		send_op(KIND_SEARCH, 1);
		send_op(KIND_SPARE, VAL_MAX);
		send_op(KIND_SPARE, 7);
		send_op(KIND_DELETE, 5);
		send_op(KIND_DELETE, VAL_MAX);
		send_op(KIND_SEARCH, VAL_MAX);
		send_op(KIND_DELETE, VAL_MIN);
		send_op(KIND_DELETE, -1);
		send_op(KIND_DELETE, 0);
		send_op(KIND_DELETE, VAL_MAX);
	endtask

	task automatic test_fill_and_refuse(input int extra_inserts);
		while (shadow_fill < CAPACITY)
			send_op(KIND_INSERT, pick_value());
		repeat (extra_inserts)
			send_op(KIND_INSERT, pick_value());
		send_op(KIND_SEARCH, pick_value());
		// drain back to empty, with some misses along the way
		while (shadow_fill > 0) begin
			if ($urandom_range(0, 3) != 0)
				send_op(KIND_DELETE, shadow_vals[$urandom_range(0, shadow_fill - 1)]);
			else
				send_op($urandom_range(0, 1) ? KIND_DELETE : KIND_SEARCH, $urandom);
		end
		send_op(KIND_DELETE, pick_value());
	endtask

	task automatic test_random_mix(input int n_ops, input int insert_pct);
		int roll;
		logic [KIND_W-1:0] kind;
		repeat (n_ops) begin
			roll = $urandom_range(0, 99);
			if (roll < insert_pct)
				kind = KIND_INSERT;
			else if (roll < insert_pct + (100 - insert_pct) * 45 / 100)
				kind = KIND_DELETE;
			else if (roll < 95)
				kind = KIND_SEARCH;
			else
				kind = KIND_SPARE;
			send_op(kind, pick_value());
		end
	endtask

	always @(posedge clk) begin : sink_ctrl
		int roll;
		if (!sink_idle) begin
			m_axis_tready <= 1'b1;
		end else if (stall_left > 0) begin
			m_axis_tready <= 1'b0;
			stall_left <= stall_left - 1;
		end else begin
			roll = $urandom_range(0, 99);
			if (roll < 60) begin
				m_axis_tready <= 1'b1;
			end else if (roll < 90) begin
				m_axis_tready <= 1'b0;
				stall_left <= $urandom_range(0, 2);
			end else begin
				m_axis_tready <= 1'b0;
				stall_left <= $urandom_range(4, 24);
			end
		end
	end

	function automatic void flag_mismatch(input string msg);
		mismatch_count++;
		if (mismatch_count <= 10)
			$display("%t mismatch: %s", $realtime, msg);
	endfunction

	always @(posedge clk) begin : result_check
		op_result_t want;
		logic [STATUS_W-1:0] got_status;
		logic [COUNT_W-1:0] got_count;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got_status = m_axis_tdata[STATUS_W-1:0];
			got_count = m_axis_tdata[STATUS_W +: COUNT_W];
			if (pending_results.size() == 0) begin
				flag_mismatch($sformatf("unexpected result transaction status=%0d count=%0d",
					got_status, got_count));
			end else begin
				want = pending_results.pop_front();
				if (got_status !== want.status)
					flag_mismatch($sformatf("status expected %0d actual %0d",
						want.status, got_status));
				if (got_count !== want.count)
					flag_mismatch($sformatf("entry_count expected %0d actual %0d",
						want.count, got_count));
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("[sorted_table_insert_search_delete_unit] ERROR");
			$finish;
		end
	end

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_empty_table();
		test_extremes();
		src_idle = 1'b1;
		sink_idle = 1'b1;
		test_random_mix(120, 50);
		test_fill_and_refuse(4);
		src_idle = 1'b0;
		test_fill_and_refuse(2);
		src_idle = 1'b1;
		sink_idle = 1'b0;
		test_random_mix(100, 60);
		sink_idle = 1'b1;
		test_random_mix(80, 40);

		s_axis_tvalid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0)
			$display("[sorted_table_insert_search_delete_unit] OK");
		else
			$display("[sorted_table_insert_search_delete_unit] ERROR");
		$finish;
	end

endmodule
